FILE: sv/aff_pkg.sv
package aff_pkg;

  localparam int PRE_SH = 6;            // 1/K product alignment (Q30 -> guard bits)
  localparam int CW     = 64 - PRE_SH;  // CORDIC x/y width
  localparam int ZW     = 34;           // angle accumulator width
  localparam int GUARD  = 24;           // extra fraction bits during iterations
  localparam int TW     = CW - GUARD;   // rounded result width before saturation

  localparam logic signed [30:0]    INV_GAIN = 31'sd652032874;
  localparam logic signed [CW-1:0]  HALF_LSB = CW'(64'd1 << (GUARD - 1));
  localparam logic signed [ZW-1:0]  Z_PI     = ZW'(64'h0000_0000_8000_0000);

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef enum logic {
    OP_COMPOSE   = 1'b0,
    OP_DECOMPOSE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_X,
    ST_LD_Y,
    ST_NEG,
    ST_ITER,
    ST_RND,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       vectoring;
    logic [4:0] k;
  } step_ctl_t;

  // round half up, then saturate to signed 32 bits
  function automatic logic signed [31:0] round_sat(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    logic        [TW-1:0] t;
    logic signed [31:0]   res;
    r = v + HALF_LSB;
    t = r[CW-1:GUARD];
    if (t[TW-1:31] == '0 || t[TW-1:31] == '1) begin
      res = t[31:0];
    end else if (t[TW-1]) begin
      res = 32'sh8000_0000;
    end else begin
      res = 32'sh7FFF_FFFF;
    end
    return res;
  endfunction

  // round half up, then clamp to 0 .. 2^31-1
  function automatic logic [30:0] round_mag(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    logic        [TW-1:0] t;
    logic        [30:0]   res;
    r = v + HALF_LSB;
    t = r[CW-1:GUARD];
    if (t[TW-1]) begin
      res = '0;
    end else if (t[TW-2:31] != '0) begin
      res = '1;
    end else begin
      res = t[30:0];
    end
    return res;
  endfunction

endpackage

FILE: sv/aff_prescale.sv
module aff_prescale (
  input  logic signed [32:0]            value_i,
  output logic signed [aff_pkg::CW-1:0] scaled_o
);

  logic signed [63:0] prod;

  // gain compensation: value * (1/K in Q30), kept with GUARD fraction bits
  assign prod     = 64'(value_i) * 64'(aff_pkg::INV_GAIN);
  assign scaled_o = prod[63:aff_pkg::PRE_SH];

endmodule

FILE: sv/aff_cordic_step.sv
module aff_cordic_step (
  input  aff_pkg::step_ctl_t            ctl_i,
  input  logic signed [aff_pkg::CW-1:0] x_i,
  input  logic signed [aff_pkg::CW-1:0] y_i,
  input  logic signed [aff_pkg::ZW-1:0] z_i,
  output logic signed [aff_pkg::CW-1:0] x_o,
  output logic signed [aff_pkg::CW-1:0] y_o,
  output logic signed [aff_pkg::ZW-1:0] z_o
);

  logic signed [aff_pkg::CW-1:0] dx;
  logic signed [aff_pkg::CW-1:0] dy;
  logic signed [aff_pkg::ZW-1:0] ang;
  logic                          up;

  assign dx  = y_i >>> ctl_i.k;
  assign dy  = x_i >>> ctl_i.k;
  assign ang = $signed({{(aff_pkg::ZW - 32){1'b0}}, aff_pkg::ATAN_TAB[ctl_i.k]});
  assign up  = ctl_i.vectoring ? ~y_i[aff_pkg::CW-1] : z_i[aff_pkg::ZW-1];

  always_comb begin
    if (up) begin
      x_o = x_i + dx;
      y_o = y_i - dy;
      z_o = z_i + ang;
    end else begin
      x_o = x_i - dx;
      y_o = y_i + dy;
      z_o = z_i - ang;
    end
  end

endmodule

FILE: sv/affine_compose_decompose.sv
// Channel   Handshake                  Payload
// input     in_valid_i / in_ready_o    operation_i, scale_i, rotation_i, shift_x_i, shift_y_i,
//                                      m00_in_i, m01_in_i, m02_in_i, m10_in_i, m12_in_i
// output    out_valid_o / out_ready_i  out_m00_o .. out_m12_o, out_scale_o, out_angle_o,
//                                      out_tx_o, out_ty_o
//
// One request at a time through a single CORDIC micro-rotation unit and one prescale multiplier.
// Compose: one rotation pass of CORDIC_STEPS micro-rotations, then rounding. Decompose: two
// vectoring passes (the second is skipped when m00 and m10 are both zero).
// in_ready_o is high only in idle; a finished result sits in the output register while the
// next request is computed, and that request holds in its last state until the register frees.
// Reset (rst_ni low) clears the sequencer and the output valid.
module affine_compose_decompose #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic signed [31:0] scale_i,
  input  logic signed [31:0] rotation_i,
  input  logic signed [31:0] shift_x_i,
  input  logic signed [31:0] shift_y_i,
  input  logic signed [31:0] m00_in_i,
  input  logic signed [31:0] m01_in_i,
  input  logic signed [31:0] m02_in_i,
  input  logic signed [31:0] m10_in_i,
  input  logic signed [31:0] m12_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_m00_o,
  output logic signed [31:0] out_m01_o,
  output logic signed [31:0] out_m02_o,
  output logic signed [31:0] out_m10_o,
  output logic signed [31:0] out_m11_o,
  output logic signed [31:0] out_m12_o,
  output logic        [30:0] out_scale_o,
  output logic signed [31:0] out_angle_o,
  output logic signed [31:0] out_tx_o,
  output logic signed [31:0] out_ty_o
);

  localparam int SW = $clog2(CORDIC_STEPS);
  localparam logic [SW-1:0] LAST_STEP = SW'(CORDIC_STEPS - 1);

  aff_pkg::state_e state_q, state_d;
  logic            pass_q, pass_d;
  logic [SW-1:0]   i_q, i_d;
  logic            out_valid_q, out_valid_d;
  logic            out_load;
  logic            in_accept;

  aff_pkg::op_e       op_q;
  logic signed [31:0] scale_q, rot_q, sx_q, sy_q;
  logic signed [31:0] m00_q, m01_q, m02_q, m10_q, m12_q;

  logic signed [aff_pkg::CW-1:0] x_q, x_d, y_q, y_d;
  logic signed [aff_pkg::ZW-1:0] z_q, z_d;
  logic signed [31:0]            c_q, c_d, s_q, s_d, ang_q, ang_d;
  logic        [30:0]            mag_q, mag_d;

  logic signed [32:0]            mul_op;
  logic signed [aff_pkg::CW-1:0] scaled;
  logic signed [aff_pkg::CW-1:0] x_step, y_step;
  logic signed [aff_pkg::ZW-1:0] z_step;
  aff_pkg::step_ctl_t            step_ctl;

  logic               wrap;
  logic signed [31:0] rot_adj;
  logic               compose;
  logic signed [31:0] neg_s;

  assign compose   = (op_q == aff_pkg::OP_COMPOSE);
  assign wrap      = rot_q[31] ^ rot_q[30];
  assign rot_adj   = wrap ? {~rot_q[31], rot_q[30:0]} : rot_q;
  assign in_accept = in_valid_i & in_ready_o;

  always_comb begin
    if (state_q == aff_pkg::ST_LD_X) begin
      if (compose) begin
        mul_op = 33'(scale_q);
      end else if (!pass_q) begin
        mul_op = m00_q[31] ? -33'(m00_q) : 33'(m00_q);
      end else begin
        mul_op = 33'(m00_q);
      end
    end else begin
      mul_op = pass_q ? 33'(m10_q) : 33'(m01_q);
    end
  end

  aff_prescale u_prescale (
    .value_i  (mul_op),
    .scaled_o (scaled)
  );

  assign step_ctl.vectoring = ~compose;
  assign step_ctl.k         = 5'(i_q);

  aff_cordic_step u_step (
    .ctl_i (step_ctl),
    .x_i   (x_q),
    .y_i   (y_q),
    .z_i   (z_q),
    .x_o   (x_step),
    .y_o   (y_step),
    .z_o   (z_step)
  );

  always_comb begin
    state_d    = state_q;
    pass_d     = pass_q;
    x_d        = x_q;
    y_d        = y_q;
    z_d        = z_q;
    c_d        = c_q;
    s_d        = s_q;
    mag_d      = mag_q;
    ang_d      = ang_q;
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      aff_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          pass_d  = 1'b0;
          state_d = aff_pkg::ST_LD_X;
        end
      end
      aff_pkg::ST_LD_X: begin
        x_d = scaled;
        if (compose) begin
          y_d     = '0;
          z_d     = aff_pkg::ZW'(rot_adj);
          state_d = aff_pkg::ST_NEG;
        end else begin
          state_d = aff_pkg::ST_LD_Y;
        end
      end
      aff_pkg::ST_LD_Y: begin
        y_d     = scaled;
        z_d     = '0;
        state_d = pass_q ? aff_pkg::ST_NEG : aff_pkg::ST_ITER;
      end
      aff_pkg::ST_NEG: begin
        if (compose) begin
          if (wrap) begin
            x_d = -x_q;
          end
        end else if (m00_q[31]) begin
          x_d = -x_q;
          y_d = -y_q;
          z_d = aff_pkg::Z_PI;
        end
        state_d = aff_pkg::ST_ITER;
      end
      aff_pkg::ST_ITER: begin
        x_d = x_step;
        y_d = y_step;
        z_d = z_step;
        if (i_q == LAST_STEP) begin
          state_d = aff_pkg::ST_RND;
        end
      end
      aff_pkg::ST_RND: begin
        if (compose) begin
          c_d     = aff_pkg::round_sat(x_q);
          s_d     = aff_pkg::round_sat(y_q);
          state_d = aff_pkg::ST_DONE;
        end else if (!pass_q) begin
          mag_d = aff_pkg::round_mag(x_q);
          if (m00_q == '0 && m10_q == '0) begin
            ang_d   = '0;
            state_d = aff_pkg::ST_DONE;
          end else begin
            pass_d  = 1'b1;
            state_d = aff_pkg::ST_LD_X;
          end
        end else begin
          ang_d   = z_q[31:0];
          state_d = aff_pkg::ST_DONE;
        end
      end
      aff_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = aff_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = aff_pkg::ST_IDLE;
      end
    endcase
  end

  assign i_d         = (state_q == aff_pkg::ST_ITER) ? i_q + 1'b1 : '0;
  assign out_valid_d = out_load | (out_valid_q & ~out_ready_i);
  assign neg_s       = (s_q == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= aff_pkg::ST_IDLE;
      pass_q      <= 1'b0;
      i_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      i_q         <= i_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q    <= aff_pkg::op_e'(operation_i);
      scale_q <= scale_i;
      rot_q   <= rotation_i;
      sx_q    <= shift_x_i;
      sy_q    <= shift_y_i;
      m00_q   <= m00_in_i;
      m01_q   <= m01_in_i;
      m02_q   <= m02_in_i;
      m10_q   <= m10_in_i;
      m12_q   <= m12_in_i;
    end
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    c_q   <= c_d;
    s_q   <= s_d;
    mag_q <= mag_d;
    ang_q <= ang_d;
    if (out_load) begin
      if (compose) begin
        out_m00_o   <= c_q;
        out_m01_o   <= neg_s;
        out_m02_o   <= sx_q;
        out_m10_o   <= s_q;
        out_m11_o   <= c_q;
        out_m12_o   <= sy_q;
        out_scale_o <= '0;
        out_angle_o <= '0;
        out_tx_o    <= '0;
        out_ty_o    <= '0;
      end else begin
        out_m00_o   <= '0;
        out_m01_o   <= '0;
        out_m02_o   <= '0;
        out_m10_o   <= '0;
        out_m11_o   <= '0;
        out_m12_o   <= '0;
        out_scale_o <= mag_q;
        out_angle_o <= ang_q;
        out_tx_o    <= m02_q;
        out_ty_o    <= m12_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
